>>> rtl/gas_pkg.sv
package gas_pkg;

	localparam int unsigned SampleWidth = 10;
	localparam int unsigned ChanWidth = 3;
	localparam int unsigned PwmWidth = 8;
	localparam int unsigned DeadZoneWidth = 9;
	localparam int unsigned ChanCountWidth = 4;
	localparam int unsigned CountWidth = 7;
	localparam int unsigned CfgIndexWidth = 3;
	localparam int unsigned CfgDataWidth = 10;

	localparam logic [CountWidth-1:0] OC_LIMIT = 7'd70;
	localparam logic [CountWidth-1:0] OC_LOW = 7'd20;
	localparam logic [SampleWidth-1:0] OC_HARD_CURRENT = 10'd150;
	localparam logic [ChanCountWidth-1:0] CH_LAST = 4'd7;
	localparam logic [ChanCountWidth-1:0] CH_NONE = 4'd8;

	localparam logic [SampleWidth-1:0] RST_FORCE_THRESHOLD = 10'd100;
	localparam logic [SampleWidth-1:0] RST_NEUTRAL_MIDDLE = 10'd512;
	localparam logic [DeadZoneWidth-1:0] RST_NEUTRAL_DEAD_ZONE = 9'd20;
	localparam logic [SampleWidth-1:0] RST_POSITION_MAX = 10'd900;
	localparam logic [SampleWidth-1:0] RST_POSITION_MIN = 10'd100;
	localparam logic [PwmWidth-1:0] RST_DRIVE_PWM = 8'd140;
	localparam logic [ChanCountWidth-1:0] RST_ADC_CHANNEL_COUNT = 4'd2;

	typedef enum logic [1:0] {
		KIND_SAMPLE = 2'd0,
		KIND_TICK   = 2'd1,
		KIND_SHIFT  = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		REQ_NONE = 2'd0,
		REQ_UP   = 2'd1,
		REQ_DOWN = 2'd2
	} shift_req_t;

	typedef enum logic [1:0] {
		CMD_NO_CHANGE = 2'd0,
		CMD_STOP      = 2'd1,
		CMD_CW        = 2'd2,
		CMD_CCW       = 2'd3
	} motor_cmd_t;

	typedef enum logic [1:0] {
		BRIDGE_NO_CHANGE = 2'd0,
		BRIDGE_DISABLE   = 2'd1,
		BRIDGE_ENABLE    = 2'd2
	} bridge_t;

	typedef enum logic [1:0] {
		CUT_NONE   = 2'd0,
		CUT_SIDE_A = 2'd1,
		CUT_SIDE_B = 2'd2
	} side_cut_t;

	typedef enum logic [CfgIndexWidth-1:0] {
		REG_FORCE_THRESHOLD   = 3'd0,
		REG_NEUTRAL_MIDDLE    = 3'd1,
		REG_NEUTRAL_DEAD_ZONE = 3'd2,
		REG_POSITION_MAX      = 3'd3,
		REG_POSITION_MIN      = 3'd4,
		REG_DRIVE_PWM         = 3'd5,
		REG_ADC_CHANNEL_COUNT = 3'd6
	} reg_index_t;

	localparam logic [ChanWidth-1:0] CH_POSITION = 3'd0;
	localparam logic [ChanWidth-1:0] CH_CURRENT = 3'd1;

endpackage

>>> rtl/gas_in_if.sv
interface gas_in_if;
	import gas_pkg::*;

	logic                   valid;
	logic                   ready;
	logic [1:0]             kind;
	logic [ChanWidth-1:0]   sample_channel;
	logic [SampleWidth-1:0] sample_value;
	logic [1:0]             shift_request;

	modport source (output valid, kind, sample_channel, sample_value, shift_request,
		input ready);
	modport sink (input valid, kind, sample_channel, sample_value, shift_request,
		output ready);
endinterface

>>> rtl/gas_out_if.sv
interface gas_out_if;
	import gas_pkg::*;

	logic                      valid;
	logic                      ready;
	logic [1:0]                motor_command;
	logic [PwmWidth-1:0]       motor_pwm;
	logic [SampleWidth-1:0]    motor_position;
	logic [1:0]                bridge_enable;
	logic [1:0]                side_cut;
	logic [ChanCountWidth-1:0] adc_start_channel;

	modport source (output valid, motor_command, motor_pwm, motor_position,
		bridge_enable, side_cut, adc_start_channel, input ready);
	modport sink (input valid, motor_command, motor_pwm, motor_position,
		bridge_enable, side_cut, adc_start_channel, output ready);
endinterface

>>> rtl/gear_actuator_supervisor_top.sv
// channel  dir  handshake      payload
// item     in   valid/ready    kind, sample_channel, sample_value, shift_request
// result   out  valid/ready    motor_command, motor_pwm, motor_position,
//                              bridge_enable, side_cut, adc_start_channel
// cfg      in   cfg_we         cfg_index, cfg_data
//
// one word per cycle while result is not stalled: input register, one level of
// compare/count logic, result register. a tick or shift word passes through the input
// register and then the result register before it shows up on result.
// samples update state only; samples and unknown kinds give no result word.
// reset clears the block state and valid flags and loads the register defaults; no clearing pass.
// a stalled result holds the result register; the input register still drains
// words that give no result and fills while the result waits.
module gear_actuator_supervisor_top (
	input  logic                                clk,
	input  logic                                arst_n,
	gas_in_if.sink                              item,
	gas_out_if.source                           result,
	input  logic                                cfg_we,
	input  logic [gas_pkg::CfgIndexWidth-1:0]   cfg_index,
	input  logic [gas_pkg::CfgDataWidth-1:0]    cfg_data
);
	import gas_pkg::*;

	// configuration
	logic [SampleWidth-1:0]    force_threshold_q;
	logic [SampleWidth-1:0]    neutral_middle_q;
	logic [DeadZoneWidth-1:0]  neutral_dead_zone_q;
	logic [SampleWidth-1:0]    position_max_q;
	logic [SampleWidth-1:0]    position_min_q;
	logic [PwmWidth-1:0]       drive_pwm_q;
	logic [ChanCountWidth-1:0] adc_channel_count_q;

	// block state
	logic [SampleWidth-1:0] position_q, position_n;
	logic [SampleWidth-1:0] current_q, current_n;
	logic [CountWidth-1:0]  oc_count_q, oc_count_n;
	logic                   ret_max_q, ret_max_n;
	logic                   ret_min_q, ret_min_n;
	logic [ChanWidth-1:0]   next_chan_q, next_chan_n;

	// input register
	logic                   valid_s1;
	logic [1:0]             kind_s1;
	logic [ChanWidth-1:0]   chan_s1;
	logic [SampleWidth-1:0] value_s1;
	logic [1:0]             req_s1;

	// result register
	logic                      res_valid_q;
	logic [1:0]                cmd_q;
	logic [PwmWidth-1:0]       pwm_q;
	logic [SampleWidth-1:0]    mpos_q;
	logic [1:0]                bridge_q;
	logic [1:0]                cut_q;
	logic [ChanCountWidth-1:0] start_q;

	logic [1:0]                cmd_c;
	logic [PwmWidth-1:0]       pwm_c;
	logic [SampleWidth-1:0]    mpos_c;
	logic [1:0]                bridge_c;
	logic [1:0]                cut_c;
	logic [ChanCountWidth-1:0] start_c;

	logic has_result;
	logic advance;
	logic drive;
	logic idle;
	logic [SampleWidth:0]     upper;
	logic signed [SampleWidth+1:0] lower;
	logic                     pos_gt_upper;
	logic                     pos_lt_lower;
	logic [ChanCountWidth-1:0] chan_inc;

	assign has_result = (kind_s1 == KIND_TICK) || (kind_s1 == KIND_SHIFT);
	assign advance = valid_s1 && (!has_result || !res_valid_q || result.ready);
	assign item.ready = !valid_s1 || advance;

	assign upper = {1'b0, neutral_middle_q} + {2'b00, neutral_dead_zone_q};
	assign lower = $signed({2'b00, neutral_middle_q}) - $signed({3'b000, neutral_dead_zone_q});
	assign pos_gt_upper = {1'b0, position_q} > upper;
	assign pos_lt_lower = $signed({2'b00, position_q}) < lower;
	assign chan_inc = {1'b0, next_chan_q} + 4'd1;
	assign idle = !ret_max_q && !ret_min_q;

	always_comb begin
		position_n = position_q;
		current_n = current_q;
		oc_count_n = oc_count_q;
		ret_max_n = ret_max_q;
		ret_min_n = ret_min_q;
		next_chan_n = next_chan_q;
		cmd_c = CMD_NO_CHANGE;
		bridge_c = BRIDGE_NO_CHANGE;
		cut_c = CUT_NONE;
		start_c = CH_NONE;
		drive = 1'b0;
		unique case (kind_s1)
			KIND_SAMPLE: begin
				if (chan_s1 == CH_POSITION) begin
					position_n = value_s1;
				end else if (chan_s1 == CH_CURRENT) begin
					current_n = value_s1;
				end
			end
			KIND_TICK: begin
				start_c = {1'b0, next_chan_q};
				if (chan_inc >= adc_channel_count_q || chan_inc > CH_LAST) begin
					next_chan_n = '0;
				end else begin
					next_chan_n = chan_inc[ChanWidth-1:0];
				end

				// above threshold counts up; the hard-current branch lands one below the limit
				if (current_q > force_threshold_q) begin
					oc_count_n = (oc_count_q >= OC_LIMIT) ? OC_LIMIT : oc_count_q + 7'd1;
				end else if (current_q > OC_HARD_CURRENT) begin
					oc_count_n = OC_LIMIT - 7'd1;
				end else if (oc_count_q != '0) begin
					oc_count_n = oc_count_q - 7'd1;
				end
				if (oc_count_n < OC_LOW) begin
					bridge_c = BRIDGE_ENABLE;
				end else if (oc_count_n >= OC_LIMIT) begin
					bridge_c = BRIDGE_DISABLE;
				end

				if (ret_max_q) begin
					if (pos_gt_upper) begin
						cmd_c = CMD_CCW;
						drive = 1'b1;
					end else begin
						cmd_c = CMD_STOP;
						ret_max_n = 1'b0;
						ret_min_n = 1'b0;
					end
				end
				if (ret_min_n) begin
					if (pos_lt_lower) begin
						cmd_c = CMD_CW;
						drive = 1'b1;
					end else begin
						cmd_c = CMD_STOP;
						drive = 1'b0;
						ret_max_n = 1'b0;
						ret_min_n = 1'b0;
					end
				end

				// limit check sees the flags after a finished return
				if (!ret_max_n && !ret_min_n) begin
					if (position_q > position_max_q) begin
						cut_c = CUT_SIDE_A;
						ret_max_n = 1'b1;
					end else if (position_q < position_min_q) begin
						cut_c = CUT_SIDE_B;
						ret_min_n = 1'b1;
					end
				end
			end
			KIND_SHIFT: begin
				if (idle && req_s1 == REQ_UP) begin
					cmd_c = CMD_CW;
					drive = 1'b1;
				end else if (idle && req_s1 == REQ_DOWN) begin
					cmd_c = CMD_CCW;
					drive = 1'b1;
				end
			end
			default: begin
			end
		endcase
		pwm_c = drive ? drive_pwm_q : '0;
		mpos_c = drive ? position_q : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			force_threshold_q <= RST_FORCE_THRESHOLD;
			neutral_middle_q <= RST_NEUTRAL_MIDDLE;
			neutral_dead_zone_q <= RST_NEUTRAL_DEAD_ZONE;
			position_max_q <= RST_POSITION_MAX;
			position_min_q <= RST_POSITION_MIN;
			drive_pwm_q <= RST_DRIVE_PWM;
			adc_channel_count_q <= RST_ADC_CHANNEL_COUNT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FORCE_THRESHOLD:   force_threshold_q <= cfg_data;
				REG_NEUTRAL_MIDDLE:    neutral_middle_q <= cfg_data;
				REG_NEUTRAL_DEAD_ZONE: neutral_dead_zone_q <= cfg_data[DeadZoneWidth-1:0];
				REG_POSITION_MAX:      position_max_q <= cfg_data;
				REG_POSITION_MIN:      position_min_q <= cfg_data;
				REG_DRIVE_PWM:         drive_pwm_q <= cfg_data[PwmWidth-1:0];
				REG_ADC_CHANNEL_COUNT: adc_channel_count_q <= cfg_data[ChanCountWidth-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q <= '0;
			current_q <= '0;
			oc_count_q <= '0;
			ret_max_q <= 1'b0;
			ret_min_q <= 1'b0;
			next_chan_q <= '0;
		end else if (advance) begin
			position_q <= position_n;
			current_q <= current_n;
			oc_count_q <= oc_count_n;
			ret_max_q <= ret_max_n;
			ret_min_q <= ret_min_n;
			next_chan_q <= next_chan_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			kind_s1 <= item.kind;
			chan_s1 <= item.sample_channel;
			value_s1 <= item.sample_value;
			req_s1 <= item.shift_request;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance && has_result) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && has_result) begin
			cmd_q <= cmd_c;
			pwm_q <= pwm_c;
			mpos_q <= mpos_c;
			bridge_q <= bridge_c;
			cut_q <= cut_c;
			start_q <= start_c;
		end
	end

	assign result.valid = res_valid_q;
	assign result.motor_command = cmd_q;
	assign result.motor_pwm = pwm_q;
	assign result.motor_position = mpos_q;
	assign result.bridge_enable = bridge_q;
	assign result.side_cut = cut_q;
	assign result.adc_start_channel = start_q;

endmodule
